>>> src/kpm_pkg.sv
// kpm_pkg: shared types and constants of the k-way position merge
// used by kpm_front, kpm_back and kway_position_merge
`default_nettype none
package kpm_pkg;

    // stream bus widths
    localparam int SDATA_W = 136;
    localparam int MDATA_W = 136;
    localparam int ROW_W   = 128;

    // configuration port
    localparam int  PADDR_W            = 3;
    localparam logic REG_ACTIVE_STREAMS = 1'b0;
    localparam logic [4:0] ACTIVE_RESET = 5'd16;

    // classified item kinds
    typedef enum logic [1:0] {
        OP_RECORD,
        OP_END,
        OP_SKIP
    } op_kind_t;

    typedef struct packed {
        op_kind_t     kind;
        logic [3:0]   idx;
        logic [62:0]  node;
        logic         rev;
        logic [31:0]  offset;
        logic [31:0]  tag;
    } kpm_item_t;

    // queue head seen by the back end
    typedef struct packed {
        logic      valid;
        kpm_item_t item;
    } kpm_q_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT,
        ST_DONE
    } kpm_state_t;

endpackage
`default_nettype wire

>>> src/kway_position_merge.sv
// kway_position_merge: top level of the k-way position merge
// depends on kpm_pkg, kpm_front and kpm_back
//
// Merges up to STREAMS presorted record streams into one stream ordered by
// node id, then strand, then offset; ties go to the lowest stream index. Send
// one record per stream (s_tlast high marks a stream's end); once every active
// stream holds a head or has ended, the smallest head comes out with its
// source stream so that stream can be refilled, and when all have ended a
// result with m_tuser high (done) comes out and the state is cleared. A small
// two-item queue decouples input acceptance from the merge engine and registers
// each accepted item. The engine takes an item in idle and checks; it returns
// to idle when no result follows, emits the done result from the done state,
// or scans, drains and emits a record. The sequential scan reads one stream
// head per cycle from the head store through a single comparator; a result
// waiting on m_tready stalls the engine until accepted.
`default_nettype none
module kway_position_merge
    import kpm_pkg::*;
#(
    parameter int STREAMS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // apb configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // input: stream_index, node_id, reverse, offset, record_tag, zero fill
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [SDATA_W-1:0] s_tdata,
    input  wire logic               s_tlast,   // stream_end
    // output: merged_node_id, merged_reverse, merged_offset, merged_tag,
    // source_stream, zero fill
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [MDATA_W-1:0]      m_tdata,
    output logic                    m_tuser    // merge_done
);

    localparam int IW = (STREAMS > 1) ? $clog2(STREAMS) : 1;
    localparam int CW = $clog2(STREAMS + 1);

    logic [4:0]    active_reg;
    logic [CW-1:0] live_n;
    kpm_q_t        q_head;
    logic          q_pop;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= ACTIVE_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_ACTIVE_STREAMS) begin
            active_reg <= pwdata[4:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ACTIVE_STREAMS) ? {27'd0, active_reg} : 32'd0;

    // clamp the active count to 1..STREAMS
    always_comb begin
        if (active_reg == 5'd0) begin
            live_n = CW'(1);
        end else if (32'(active_reg) > STREAMS) begin
            live_n = CW'(STREAMS);
        end else begin
            live_n = CW'(active_reg);
        end
    end

    kpm_front #(
        .CW(CW)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .live_n   (live_n),
        .q_pop    (q_pop),
        .q_head   (q_head)
    );

    kpm_back #(
        .STREAMS (STREAMS),
        .IW      (IW),
        .CW      (CW)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .live_n   (live_n),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

>>> src/kpm_front.sv
// kpm_front: accepts input items, classifies them and queues them
// depends on kpm_pkg
`default_nettype none
module kpm_front
    import kpm_pkg::*;
#(
    parameter int CW = 5
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [SDATA_W-1:0] s_tdata,
    input  wire logic               s_tlast,
    input  wire logic [CW-1:0]      live_n,
    input  wire logic               q_pop,
    output kpm_q_t                  q_head
);

    kpm_item_t  fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    kpm_item_t  item;
    logic       push;
    logic       pop;

    // classify the incoming item
    always_comb begin
        item.idx    = s_tdata[3:0];
        item.node   = s_tdata[66:4];
        item.rev    = s_tdata[67];
        item.offset = s_tdata[99:68];
        item.tag    = s_tdata[131:100];
        if ((CW+4)'(s_tdata[3:0]) >= (CW+4)'(live_n)) begin
            item.kind = OP_SKIP;
        end else if (s_tlast) begin
            item.kind = OP_END;
        end else begin
            item.kind = OP_RECORD;
        end
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && (cnt_reg != 2'd0);

    assign q_head.valid = (cnt_reg != 2'd0);
    assign q_head.item  = fifo_reg[rd_ptr_reg];

    // queue pointers
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= item;
        end
    end

endmodule
`default_nettype wire

>>> src/kpm_back.sv
// kpm_back: head store, readiness check, sequential minimum scan and result register
// depends on kpm_pkg
`default_nettype none
module kpm_back
    import kpm_pkg::*;
#(
    parameter int STREAMS = 16,
    parameter int IW      = 4,
    parameter int CW      = 5
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [CW-1:0]      live_n,
    input  wire kpm_q_t             q_head,
    output logic                    q_pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [MDATA_W-1:0]      m_tdata,
    output logic                    m_tuser
);

    kpm_state_t state_reg, state_next;

    logic [ROW_W-1:0]   head_mem [STREAMS];
    logic [ROW_W-1:0]   rd_row_reg;
    logic [STREAMS-1:0] valid_reg;
    logic [STREAMS-1:0] fin_reg;
    logic [STREAMS-1:0] active_mask;

    logic [CW-1:0]      rd_idx_reg;
    logic [IW-1:0]      cmp_idx_reg;
    logic               cmp_en_reg;
    logic [IW-1:0]      best_idx_reg;
    logic [ROW_W-1:0]   best_row_reg;
    logic               any_reg;

    logic               m_tvalid_reg;
    logic [MDATA_W-1:0] m_data_reg;
    logic               m_user_reg;

    logic               out_free;
    logic               all_ready;
    logic               any_valid;
    logic               rd_en;
    logic               take;
    logic               emit_rec;
    logic               emit_done;
    logic [IW-1:0]      q_idx;
    logic               better;

    // active streams mask
    for (genvar g = 0; g < STREAMS; g++) begin : g_mask
        assign active_mask[g] = (CW'(g) < live_n);
    end

    assign all_ready = &(valid_reg | fin_reg | ~active_mask);
    assign any_valid = |(valid_reg & active_mask);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign q_idx     = IW'(q_head.item.idx);
    assign better    = !any_reg || (rd_row_reg[ROW_W-1:32] < best_row_reg[ROW_W-1:32]);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (q_head.valid) state_next = ST_CHECK;
            ST_CHECK: begin
                if (!all_ready) begin
                    state_next = ST_IDLE;
                end else if (!any_valid) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:  if (rd_idx_reg == live_n - CW'(1)) state_next = ST_DRAIN;
            ST_DRAIN: state_next = ST_EMIT;
            ST_EMIT:  if (out_free) state_next = ST_IDLE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        take      = 1'b0;
        rd_en     = 1'b0;
        emit_rec  = 1'b0;
        emit_done = 1'b0;
        case (state_reg)
            ST_IDLE: take      = q_head.valid;
            ST_SCAN: rd_en     = 1'b1;
            ST_EMIT: emit_rec  = out_free;
            ST_DONE: emit_done = out_free;
            default: ;
        endcase
    end

    assign q_pop = take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // head and end flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            fin_reg   <= '0;
        end else if (emit_done) begin
            valid_reg <= '0;
            fin_reg   <= '0;
        end else if (emit_rec) begin
            valid_reg[best_idx_reg] <= 1'b0;
        end else if (take) begin
            if (q_head.item.kind == OP_END) begin
                fin_reg[q_idx] <= 1'b1;
            end else if (q_head.item.kind == OP_RECORD && !valid_reg[q_idx]
                         && !fin_reg[q_idx]) begin
                valid_reg[q_idx] <= 1'b1;
            end
        end
    end

    // head store, written on a record and read by the scan
    always_ff @(posedge aclk) begin
        if (take && q_head.item.kind == OP_RECORD && !valid_reg[q_idx]
            && !fin_reg[q_idx]) begin
            head_mem[q_idx] <= {q_head.item.node, q_head.item.rev,
                                q_head.item.offset, q_head.item.tag};
        end
        if (rd_en) begin
            rd_row_reg <= head_mem[rd_idx_reg[IW-1:0]];
        end
    end

    // scan counter and compare stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_idx_reg <= '0;
            cmp_en_reg <= 1'b0;
            any_reg    <= 1'b0;
        end else begin
            cmp_en_reg <= rd_en;
            if (state_reg == ST_CHECK) begin
                rd_idx_reg <= '0;
                any_reg    <= 1'b0;
            end else begin
                if (rd_en) begin
                    rd_idx_reg <= rd_idx_reg + CW'(1);
                end
                if (cmp_en_reg && valid_reg[cmp_idx_reg] && better) begin
                    any_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg <= rd_idx_reg[IW-1:0];
        if (cmp_en_reg && valid_reg[cmp_idx_reg] && better) begin
            best_idx_reg <= cmp_idx_reg;
            best_row_reg <= rd_row_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit_rec || emit_done) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_done) begin
            m_data_reg <= '0;
            m_user_reg <= 1'b1;
        end else if (emit_rec) begin
            m_data_reg <= {4'd0, 4'(best_idx_reg), best_row_reg[31:0],
                           best_row_reg[63:32], best_row_reg[64], best_row_reg[127:65]};
            m_user_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
`default_nettype wire

>>> tb/sv/tb_kway_position_merge.sv
// tb_kway_position_merge: self-checking testbench for the k-way position merge
// depends on kpm_pkg and kway_position_merge; predicts each merged item and
// compares it field by field while both stream sides idle at random
`timescale 1ns / 100ps
module tb_kway_position_merge;
    import kpm_pkg::*;

    localparam int NSTR = 16;
    localparam logic [PADDR_W-1:0] ADDR_ACTIVE = PADDR_W'(4 * REG_ACTIVE_STREAMS);
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [62:0] node;
        logic        rev;
        logic [31:0] offset;
        logic [31:0] tag;
        logic [3:0]  src;
        logic        done;
    } merge_res_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [SDATA_W-1:0] s_tdata = '0;   // stream_index, node_id, reverse, offset, record_tag
    logic               s_tlast = 1'b0; // stream_end
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [MDATA_W-1:0] m_tdata;        // node_id, reverse, offset, tag, source_stream
    logic               m_tuser;        // merge_done

    kway_position_merge #(.STREAMS(NSTR)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // predictor state: one head per stream plus the stream count register
    logic [62:0] hd_node [NSTR];
    logic        hd_rev [NSTR];
    logic [31:0] hd_off [NSTR];
    logic [31:0] hd_tag [NSTR];
    bit          hd_valid [NSTR];
    bit          hd_ended [NSTR];
    logic [4:0]  active_reg = ACTIVE_RESET;

    merge_res_t expected_merges[$];
    int         mismatches = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         items_sent = 0;

    // per-stream feeder state for well-formed merges
    int          left_recs [NSTR];
    logic [62:0] last_node [NSTR];

    function automatic int live_streams();
        if (active_reg == 0) return 1;
        if (active_reg > NSTR) return NSTR;
        return int'(active_reg);
    endfunction

    function automatic bit key_less(int x, int y);
        if (hd_node[x] != hd_node[y]) return hd_node[x] < hd_node[y];
        if (hd_rev[x] != hd_rev[y]) return hd_rev[x] < hd_rev[y];
        return hd_off[x] < hd_off[y];
    endfunction

    // apply one accepted item and queue the merged item it produces, if any
    task automatic merge_predict(input logic [3:0] idx, input logic [62:0] node,
                                 input logic rev, input logic [31:0] off,
                                 input logic [31:0] tag, input logic endm);
        int n;
        int best;
        bit any;
        merge_res_t r;
        n = live_streams();
        best = 0;
        any = 0;
        r = '0;
        if (idx < n) begin
            if (endm) begin
                hd_ended[idx] = 1;
            end else if (!hd_valid[idx] && !hd_ended[idx]) begin
                hd_node[idx] = node;
                hd_rev[idx] = rev;
                hd_off[idx] = off;
                hd_tag[idx] = tag;
                hd_valid[idx] = 1;
            end
        end
        for (int i = 0; i < n; i++)
            if (!hd_valid[i] && !hd_ended[i]) return;
        for (int i = 0; i < n; i++) begin
            if (hd_valid[i] && (!any || key_less(i, best))) begin
                best = i;
                any = 1;
            end
        end
        if (!any) begin
            r.done = 1'b1;
            for (int i = 0; i < NSTR; i++) begin
                hd_valid[i] = 0;
                hd_ended[i] = 0;
            end
        end else begin
            r.node = hd_node[best];
            r.rev = hd_rev[best];
            r.offset = hd_off[best];
            r.tag = hd_tag[best];
            r.src = 4'(best);
            hd_valid[best] = 0;
        end
        expected_merges = {expected_merges, r};
    endtask

    // drive one item, wait for acceptance, then predict
    task automatic send_item(input logic [3:0] idx, input logic [62:0] node,
                             input logic rev, input logic [31:0] off,
                             input logic [31:0] tag, input logic endm);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, tag, off, rev, node, idx};
        s_tlast <= endm;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        merge_predict(idx, node, rev, off, tag, endm);
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] exp_v,
                                   input logic [63:0] got_v);
        $display("%0t: %s expected %h got %h", $realtime, field, exp_v, got_v);
        mismatches++;
    endtask

    // result side: random stalls, compare every accepted item
    always @(posedge aclk) begin
        merge_res_t e;
        m_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_merges.size() == 0) begin
                report_mismatch("unexpected item, tdata low", 64'(m_tdata), 64'(m_tuser));
            end else begin
                e = expected_merges.pop_front();
                if (m_tuser !== e.done)
                    report_mismatch("merge_done", 64'(e.done), 64'(m_tuser));
                if (m_tdata[62:0] !== e.node)
                    report_mismatch("node_id", 64'(e.node), 64'(m_tdata[62:0]));
                if (m_tdata[63] !== e.rev)
                    report_mismatch("reverse", 64'(e.rev), 64'(m_tdata[63]));
                if (m_tdata[95:64] !== e.offset)
                    report_mismatch("offset", 64'(e.offset), 64'(m_tdata[95:64]));
                if (m_tdata[127:96] !== e.tag)
                    report_mismatch("tag", 64'(e.tag), 64'(m_tdata[127:96]));
                if (m_tdata[131:128] !== e.src)
                    report_mismatch("source_stream", 64'(e.src), 64'(m_tdata[131:128]));
            end
        end
    end

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_merges.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // apb write: setup then access, only while the block is idle
    task automatic write_active(input logic [31:0] value);
        wait_idle();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_ACTIVE;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        active_reg = value[4:0];
    endtask

    task automatic test_extremes_and_ties();
        write_active(32'd4);
        send_item(4'd9, '1, 1'b1, '1, '1, 1'b0);     // inactive stream
        send_item(4'd0, '1, 1'b1, '1, 32'h0, 1'b0);
        send_item(4'd0, 63'h5, 1'b0, 32'h7, 32'h1, 1'b0); // dropped, head held
        send_item(4'd1, '0, 1'b0, '0, '0, 1'b1);
        send_item(4'd1, 63'h1, 1'b0, 32'h1, 32'h2, 1'b0); // dropped, ended
        send_item(4'd2, '0, 1'b0, '0, '1, 1'b0);
        send_item(4'd3, '0, 1'b0, '0, 32'h3, 1'b0);  // tie, lower stream first
        send_item(4'd2, '0, 1'b0, '0, '0, 1'b1);
        send_item(4'd3, '0, 1'b0, '0, '0, 1'b1);
        send_item(4'd0, '0, 1'b0, '0, '0, 1'b1);
        // strand and offset order on equal node ids
        write_active(32'd16);
        for (int i = 0; i < NSTR; i++)
            send_item(4'(i), 63'h40, 1'(i < 8), 32'(15 - i), 32'(i), 1'b0);
        for (int i = 0; i < NSTR; i++) send_item(4'(i), '0, 1'b0, '0, '0, 1'b1);
    endtask

    task automatic test_register_limits();
        // zero counts as one stream
        write_active(32'd0);
        send_item(4'd0, 63'h123, 1'b1, 32'h9, 32'h55, 1'b0);
        send_item(4'd1, 63'h1, 1'b0, 32'h0, 32'h0, 1'b0);
        send_item(4'd0, '0, 1'b0, '0, '0, 1'b1);
        // end mark on a stream holding a head; the other stream's end emits it, a repeat end the done
        write_active(32'd2);
        send_item(4'd0, 63'h77, 1'b0, 32'h1, 32'hAA, 1'b0);
        send_item(4'd0, '0, 1'b0, '0, '0, 1'b1);
        send_item(4'd1, '0, 1'b0, '0, '0, 1'b1);
        send_item(4'd1, '0, 1'b0, '0, '0, 1'b1);
        // above the stream count clamps to all streams
        write_active(32'd31);
        send_item(4'd15, '0, 1'b0, '0, '0, 1'b1);
        write_active(32'd16);
        for (int i = 0; i < NSTR - 1; i++) send_item(4'(i), '0, 1'b0, '0, '0, 1'b1);
    endtask

    // one full merge driven from the predicted heads, with some noise mixed in
    task automatic run_merge(input int max_recs, input bit narrow);
        int n;
        int s;
        bit finished;
        logic [62:0] nd;
        n = live_streams();
        for (int i = 0; i < NSTR; i++) begin
            left_recs[i] = $urandom_range(max_recs);
            last_node[i] = narrow ? 63'($urandom_range(3)) : 63'({$urandom, $urandom} >> 2);
        end
        finished = 0;
        while (!finished) begin
            s = -1;
            for (int i = n - 1; i >= 0; i--)
                if (!hd_valid[i] && !hd_ended[i]) s = i;
            if ($urandom_range(99) < 8) begin
                send_item(4'($urandom_range(NSTR - 1)), 63'({$urandom, $urandom}),
                          1'($urandom), $urandom, $urandom, $urandom_range(99) < 4);
            end else if (s < 0) begin
                // every head pending on ended streams: a repeat end mark moves it
                send_item(4'($urandom_range(n - 1)), '0, 1'b0, '0, '0, 1'b1);
            end else if (left_recs[s] == 0) begin
                send_item(4'(s), 63'({$urandom, $urandom}), 1'($urandom), $urandom,
                          $urandom, 1'b1);
            end else begin
                left_recs[s]--;
                if (narrow) nd = last_node[s] + 63'($urandom_range(2));
                else nd = 63'(last_node[s] + {$urandom, $urandom} >> ($urandom_range(30) + 2));
                if (nd < last_node[s]) nd = last_node[s];
                last_node[s] = nd;
                send_item(4'(s), nd, 1'($urandom), narrow ? 32'($urandom_range(3)) : $urandom,
                          $urandom, 1'b0);
            end
            if (expected_merges.size() != 0 && expected_merges[$].done) finished = 1;
            for (int i = 0; i < NSTR; i++)
                if (hd_valid[i] || hd_ended[i]) finished = 0;
        end
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input int items);
        int counts [5];
        int sent_before;
        counts = '{1, 2, 16, 31, 0};
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        sent_before = items_sent;
        while (items_sent - sent_before < items) begin
            if ($urandom_range(3) == 0) write_active(counts[$urandom_range(4)]);
            else write_active($urandom_range(31));
            run_merge(live_streams() > 8 ? 6 : 10, $urandom_range(1));
        end
    endtask

    initial begin
        for (int i = 0; i < NSTR; i++) begin
            hd_valid[i] = 0;
            hd_ended[i] = 0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes_and_ties();
        test_register_limits();
        test_random_phase(0, 0, 330);
        test_random_phase(50, 0, 330);
        test_random_phase(0, 50, 330);
        test_random_phase(29, 29, 330);
        recv_stall_pct = 0;
        wait_idle();
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // guard against a hung handshake
    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
